// ----- rtl/page_bitmap_offset_writer_defines.svh -----
// Assertion macros for the page bitmap offset writer.
`ifndef PAGE_BITMAP_OFFSET_WRITER_DEFINES_SVH
`define PAGE_BITMAP_OFFSET_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
`define PBOW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pbow assertion failed");
`define PBOW_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("pbow reset assertion failed");
`else
`define PBOW_ASSERT(label, clk, rst, prop)
`define PBOW_ASSERT_RST(label, clk, prop)
`endif

`endif

// ----- rtl/pbow_pkg.sv -----
// Package: types, constants and helpers for the page bitmap offset writer.
package pbow_pkg;

   localparam int MAX_COLUMNS = 128;
   localparam int MAX_PAGES   = 8;

   localparam int COL_W   = $clog2(MAX_COLUMNS);
   localparam int WIDTH_W = ($clog2(MAX_COLUMNS + 1) > 8) ? $clog2(MAX_COLUMNS + 1) : 8;
   localparam int PAGE_W  = ($clog2(MAX_PAGES + 1) > 4) ? $clog2(MAX_PAGES + 1) : 4;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   localparam int HDR_LEN   = 11;
   localparam int HDR_IDX_W = 4;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [7:0] BUS_CMD_PREFIX  = 8'h00;
   localparam logic [7:0] CMD_ADDR_MODE   = 8'h20;
   localparam logic [7:0] MODE_HORIZONTAL = 8'h00;
   localparam logic [7:0] CMD_COL_ADDR    = 8'h21;
   localparam logic [7:0] CMD_PAGE_ADDR   = 8'h22;
   localparam logic [7:0] BUS_DATA_PREFIX = 8'h40;

   typedef enum logic [1:0] {
      KIND_START  = 2'd0,
      KIND_BITMAP = 2'd1,
      KIND_FLUSH  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_COL     = 2'd0,
      CSR_START_ROW_PIX = 2'd1,
      CSR_WIDTH         = 2'd2,
      CSR_FIELD_HEIGHT  = 2'd3
   } csr_index_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_HDR
   } back_state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] pixel_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       transfer_first;
      logic       transfer_last;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [6:0] start_col;
      logic [5:0] start_row_pix;
      logic [7:0] width;
      logic [6:0] field_height_pix;
   } cfg_type;

   typedef struct packed {
      logic       is_start;
      logic [7:0] data;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic                 empty;
      logic [CMD_CNT_W-1:0] count;
   } queue_status_type;

   function automatic logic [WIDTH_W-1:0] eff_width(input cfg_type c);
      logic [WIDTH_W-1:0] w;
      w = WIDTH_W'(c.width);
      if (w > WIDTH_W'(MAX_COLUMNS)) begin
         w = WIDTH_W'(MAX_COLUMNS);
      end
      return w;
   endfunction

   function automatic logic [PAGE_W-1:0] eff_pages(input cfg_type c);
      logic [PAGE_W-1:0] p;
      p = PAGE_W'(c.field_height_pix[6:3]);
      if (p > PAGE_W'(MAX_PAGES)) begin
         p = PAGE_W'(MAX_PAGES);
      end
      return p;
   endfunction

   function automatic rsp_type hdr_item(input logic [HDR_IDX_W-1:0] idx, input cfg_type c);
      rsp_type            r;
      logic [WIDTH_W-1:0] w;
      logic [PAGE_W-1:0]  p;
      logic               empty;
      logic [7:0]         page0;
      logic [7:0]         end_page;
      logic [7:0]         col_end;
      w        = eff_width(c);
      p        = eff_pages(c);
      empty    = (w == '0) || (p == '0);
      page0    = 8'(c.start_row_pix[5:3]);
      end_page = page0 + 8'(p) - 8'd1 + 8'(c.start_row_pix[2:0] != 3'd0);
      col_end  = 8'(c.start_col) + 8'(w) - 8'd1;
      r        = '0;
      case (idx)
         4'd0: begin
            r.out_byte       = BUS_CMD_PREFIX;
            r.transfer_first = 1'b1;
         end
         4'd1: r.out_byte = CMD_ADDR_MODE;
         4'd2: begin
            r.out_byte      = MODE_HORIZONTAL;
            r.transfer_last = 1'b1;
         end
         4'd3: begin
            r.out_byte       = BUS_CMD_PREFIX;
            r.transfer_first = 1'b1;
         end
         4'd4: r.out_byte = CMD_COL_ADDR;
         4'd5: r.out_byte = 8'(c.start_col);
         4'd6: r.out_byte = col_end;
         4'd7: r.out_byte = CMD_PAGE_ADDR;
         4'd8: r.out_byte = page0;
         4'd9: begin
            r.out_byte      = end_page;
            r.transfer_last = 1'b1;
         end
         4'd10: begin
            r.out_byte       = BUS_DATA_PREFIX;
            r.transfer_first = 1'b1;
            r.transfer_last  = empty;
            r.run_last       = 1'b1;
         end
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/pbow_front.sv -----
// Front end: accepts requests, tracks the window, shifts bytes and keeps the spill memory.
module pbow_front
   import pbow_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  req_type          req_item,
   input  cfg_type          cfg,
   input  queue_status_type q_status,
   output logic             cmd_push,
   output cmd_type          cmd_out
);

   typedef struct packed {
      logic       is_start;
      logic [7:0] shifted;
      logic       use_rd;
      logic       last;
   } stage_type;

   logic [7:0] spill_mem [MAX_COLUMNS];

   logic [COL_W-1:0]  col_ff, col_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [COL_W-1:0]  flush_ff, flush_in;
   logic              active_ff, active_in;
   logic              s1_valid_ff, s1_valid_in;
   stage_type         s1_ff, s1_in;
   logic [7:0]        rd_ff;

   logic               accept;
   logic [WIDTH_W-1:0] w;
   logic [PAGE_W-1:0]  pages;
   logic [2:0]         off;
   logic [15:0]        shifted16;
   logic               bitmap_ok;
   logic               flush_ok;
   logic [WIDTH_W-1:0] col_next;
   logic [WIDTH_W-1:0] flush_next;
   logic               mem_we;
   logic [COL_W-1:0]   rd_addr;

   assign req_full = (CMD_CNT_W'(q_status.count) + CMD_CNT_W'(s1_valid_ff))
                     >= CMD_CNT_W'(CMD_DEPTH);
   assign accept   = req_push && !req_full;
   assign w        = eff_width(cfg);
   assign pages    = eff_pages(cfg);
   assign off      = cfg.start_row_pix[2:0];
   assign shifted16 = 16'(req_item.pixel_byte) << off;
   assign col_next   = WIDTH_W'(col_ff) + WIDTH_W'(1);
   assign flush_next = WIDTH_W'(flush_ff) + WIDTH_W'(1);
   assign bitmap_ok = active_ff && (page_ff < pages) && (WIDTH_W'(col_ff) < w);
   assign flush_ok  = active_ff && (off != 3'd0) && (page_ff >= pages)
                      && (WIDTH_W'(flush_ff) < w);

   always_comb begin
      col_in      = col_ff;
      page_in     = page_ff;
      flush_in    = flush_ff;
      active_in   = active_ff;
      s1_valid_in = 1'b0;
      s1_in       = '0;
      mem_we      = 1'b0;
      rd_addr     = col_ff;
      if (accept) begin
         case (req_item.kind)
            KIND_START: begin
               col_in         = '0;
               page_in        = '0;
               flush_in       = '0;
               active_in      = (w != '0) && (pages != '0);
               s1_valid_in    = 1'b1;
               s1_in.is_start = 1'b1;
            end
            KIND_BITMAP: begin
               if (bitmap_ok) begin
                  mem_we        = 1'b1;
                  s1_valid_in   = 1'b1;
                  s1_in.shifted = shifted16[7:0];
                  s1_in.use_rd  = (page_ff != '0);
                  col_in        = col_next[COL_W-1:0];
                  if (col_next >= w) begin
                     col_in  = '0;
                     page_in = page_ff + PAGE_W'(1);
                     if ((page_ff + PAGE_W'(1) >= pages) && (off == 3'd0)) begin
                        active_in  = 1'b0;
                        s1_in.last = 1'b1;
                     end
                  end
               end
            end
            KIND_FLUSH: begin
               if (flush_ok) begin
                  rd_addr      = flush_ff;
                  s1_valid_in  = 1'b1;
                  s1_in.use_rd = 1'b1;
                  flush_in     = flush_next[COL_W-1:0];
                  if (flush_next >= w) begin
                     active_in  = 1'b0;
                     s1_in.last = 1'b1;
                  end
               end
            end
            default: s1_valid_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         spill_mem[col_ff] <= shifted16[15:8];
      end
      rd_ff <= spill_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         page_ff     <= '0;
         flush_ff    <= '0;
         active_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         page_ff     <= page_in;
         flush_ff    <= flush_in;
         active_ff   <= active_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   assign cmd_push         = s1_valid_ff;
   assign cmd_out.is_start = s1_ff.is_start;
   assign cmd_out.data     = s1_ff.shifted | (s1_ff.use_rd ? rd_ff : 8'h00);
   assign cmd_out.last     = s1_ff.last;

endmodule

// ----- rtl/pbow_cmd_queue.sv -----
// Short command queue between the front and back ends.
module pbow_cmd_queue
   import pbow_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head,
   output queue_status_type status
);

   cmd_type              entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + CMD_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CMD_CNT_W'(push) - CMD_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule

// ----- rtl/pbow_back.sv -----
// Back end: expands start commands into header bytes, passes data commands through and buffers results.
module pbow_back
   import pbow_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  cmd_type          head,
   input  queue_status_type q_status,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_item
);

   back_state_type       state_ff, state_in;
   logic [HDR_IDX_W-1:0] idx_ff, idx_in;
   rsp_type              out0_ff, out0_in;
   rsp_type              out1_ff, out1_in;
   logic [1:0]           out_cnt_ff, out_cnt_in;

   logic    room;
   logic    emit;
   rsp_type item;
   logic    do_pop;

   assign room   = (out_cnt_ff != 2'd2);
   assign do_pop = rsp_pop && (out_cnt_ff != 2'd0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!q_status.empty && room && head.is_start) begin
               state_in = BACK_HDR;
            end
         end
         BACK_HDR: begin
            if (room && (idx_ff == HDR_IDX_W'(HDR_LEN - 1))) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      emit   = 1'b0;
      item   = '0;
      q_pop  = 1'b0;
      idx_in = idx_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!q_status.empty && room) begin
               emit = 1'b1;
               if (head.is_start) begin
                  item   = hdr_item('0, cfg);
                  idx_in = HDR_IDX_W'(1);
               end else begin
                  item.out_byte      = head.data;
                  item.transfer_last = head.last;
                  item.run_last      = 1'b1;
                  q_pop              = 1'b1;
               end
            end
         end
         BACK_HDR: begin
            if (room) begin
               emit   = 1'b1;
               item   = hdr_item(idx_ff, cfg);
               idx_in = idx_ff + HDR_IDX_W'(1);
               if (idx_ff == HDR_IDX_W'(HDR_LEN - 1)) begin
                  q_pop = 1'b1;
               end
            end
         end
         default: emit = 1'b0;
      endcase
   end

   always_comb begin
      out0_in    = out0_ff;
      out1_in    = out1_ff;
      out_cnt_in = out_cnt_ff + 2'(emit) - 2'(do_pop);
      case (out_cnt_ff)
         2'd0: begin
            if (emit) out0_in = item;
         end
         2'd1: begin
            if (emit && do_pop) begin
               out0_in = item;
            end else if (emit) begin
               out1_in = item;
            end
         end
         2'd2: begin
            if (do_pop) out0_in = out1_ff;
         end
         default: out_cnt_in = out_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BACK_IDLE;
         idx_ff     <= '0;
         out_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      out0_ff <= out0_in;
      out1_ff <= out1_in;
   end

   assign rsp_empty = (out_cnt_ff == 2'd0);
   assign rsp_item  = out0_ff;

endmodule

// ----- rtl/page_bitmap_offset_writer.sv -----
// Top level: page-organized bitmap writer with vertical pixel offset.
//
// Requests enter through req_push/req_full: start (emits 11 header bytes),
// bitmap byte (one data byte, shifted by the row offset and merged with the
// spill of the page above) or flush (one byte of the final spill page).
// Stray requests are taken and give no result.
// Results leave through rsp_empty/rsp_pop, oldest first, one per pop.
// Registers are written through csr_we/csr_index/csr_wdata; the user must
// write them only while idle, the block does not enforce it. Results pass
// the front stage, command queue and result buffer registers. Throughput:
// one bitmap or flush request per cycle while req_full is low; a start
// emits one header byte per cycle while the buffer has room. Spill memory
// is read at the current or flush column, written at the current column.
// A four-entry command queue decouples front and back; the two-entry result
// buffer lets the back end keep working while a result waits. When rsp_pop
// stays low the buffers fill and req_full rises. Reset clears counters,
// queues and registers (width 128, height 64); spill memory is not cleared.
`include "page_bitmap_offset_writer_defines.svh"

module page_bitmap_offset_writer
   import pbow_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_item,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   logic             cmd_push;
   cmd_type          cmd_in;
   cmd_type          q_head;
   logic             q_pop;
   queue_status_type q_status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_START_COL:     cfg_in.start_col        = csr_wdata[6:0];
            CSR_START_ROW_PIX: cfg_in.start_row_pix    = csr_wdata[5:0];
            CSR_WIDTH:         cfg_in.width            = csr_wdata[7:0];
            CSR_FIELD_HEIGHT:  cfg_in.field_height_pix = csr_wdata[6:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_col        <= 7'd0;
         cfg_ff.start_row_pix    <= 6'd0;
         cfg_ff.width            <= 8'd128;
         cfg_ff.field_height_pix <= 7'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pbow_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .cmd_push (cmd_push),
      .cmd_out  (cmd_in)
   );

   pbow_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd_in),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   pbow_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (q_head),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   `PBOW_ASSERT(a_queue_bound, clock, reset, q_status.count <= CMD_CNT_W'(CMD_DEPTH))
   `PBOW_ASSERT(a_no_push_full, clock, reset, cmd_push |-> (q_status.count < CMD_CNT_W'(CMD_DEPTH)))
   `PBOW_ASSERT(a_pop_not_empty, clock, reset, q_pop |-> !q_status.empty)
   `PBOW_ASSERT_RST(a_reset_empty, clock, reset |=> (rsp_empty && q_status.empty))

endmodule
